/* hdl/pilot_state_detector_macros.svh */
// assertion helpers for the pilot state detector
`ifndef PILOT_STATE_DETECTOR_MACROS_SVH
`define PILOT_STATE_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pilot state detector check failed");

// next-cycle implication, disabled during reset
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pilot state detector check failed");

`endif

/* hdl/psd_pkg.sv */
`default_nettype none
package psd_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int STABLE_COUNT = 3;
  localparam int CNT_W        = $clog2(STABLE_COUNT + 1);
  localparam int OFFSET_W     = 12;
  localparam int GAIN_W       = 16;
  localparam int FRAC_BITS    = 12;
  localparam int MV_W         = 16;
  localparam int DIFF_W       = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
  localparam int PROD_W       = DIFF_W + GAIN_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_ACTIVE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q12          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_NOT_CONNECTED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_CONNECTED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_READY         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THR_VENTILATION   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THR_NEG_RAIL      = 3'd7;

  // vehicle state codes
  localparam logic [2:0] ST_STANDBY     = 3'd0;
  localparam logic [2:0] ST_CONNECTED   = 3'd1;
  localparam logic [2:0] ST_CHARGING    = 3'd2;
  localparam logic [2:0] ST_VENTILATION = 3'd3;
  localparam logic [2:0] ST_NO_POWER    = 3'd4;
  localparam logic [2:0] ST_ERROR       = 3'd5;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_mv;
    logic                   sample_valid;
    logic                   window_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             vehicle_state;
    logic signed [MV_W-1:0] high_mv;
    logic signed [MV_W-1:0] low_mv;
    logic                   state_changed;
    logic                   window_empty;
  } out_item_t;

  typedef struct packed {
    logic                   pwm_active;
    logic [OFFSET_W-1:0]    zero_offset;
    logic [GAIN_W-1:0]      gain_q12;
    logic signed [MV_W-1:0] thr_not_connected;
    logic signed [MV_W-1:0] thr_connected;
    logic signed [MV_W-1:0] thr_ready;
    logic signed [MV_W-1:0] thr_ventilation;
    logic signed [MV_W-1:0] thr_neg_rail;
  } cfg_t;

  // closed window
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [SAMPLE_BITS-1:0] trough;
    logic                   seen;
  } win_t;

  // scaled products of a closed window
  typedef struct packed {
    logic signed [PROD_W-1:0] high_prod;
    logic signed [PROD_W-1:0] low_prod;
    logic                     empty;
  } prod_t;

endpackage
`default_nettype wire

/* hdl/psd_regs.sv */
`default_nettype none
module psd_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output psd_pkg::cfg_t                       cfg
);
  import psd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PWM_ACTIVE:        cfg_nxt.pwm_active        = cfg_wdata[0];
        REG_ZERO_OFFSET:       cfg_nxt.zero_offset       = cfg_wdata[OFFSET_W-1:0];
        REG_GAIN_Q12:          cfg_nxt.gain_q12          = cfg_wdata[GAIN_W-1:0];
        REG_THR_NOT_CONNECTED: cfg_nxt.thr_not_connected = $signed(cfg_wdata[MV_W-1:0]);
        REG_THR_CONNECTED:     cfg_nxt.thr_connected     = $signed(cfg_wdata[MV_W-1:0]);
        REG_THR_READY:         cfg_nxt.thr_ready         = $signed(cfg_wdata[MV_W-1:0]);
        REG_THR_VENTILATION:   cfg_nxt.thr_ventilation   = $signed(cfg_wdata[MV_W-1:0]);
        REG_THR_NEG_RAIL:      cfg_nxt.thr_neg_rail      = $signed(cfg_wdata[MV_W-1:0]);
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_active        <= 1'b0;
      cfg_r.zero_offset       <= '0;
      cfg_r.gain_q12          <= 16'd4096;
      cfg_r.thr_not_connected <= 16'sd11000;
      cfg_r.thr_connected     <= 16'sd8000;
      cfg_r.thr_ready         <= 16'sd5000;
      cfg_r.thr_ventilation   <= 16'sd2000;
      cfg_r.thr_neg_rail      <= -16'sd11000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* hdl/psd_window.sv */
`default_nettype none
module psd_window (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire psd_pkg::in_item_t in_data,
  output logic                   win_valid,
  input  wire logic              win_ready,
  output psd_pkg::win_t          win
);
  import psd_pkg::*;

  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [SAMPLE_BITS-1:0] trough_r, trough_nxt;
  logic                   seen_r, seen_nxt;
  logic                   win_valid_r, win_valid_nxt;
  win_t                   win_r, win_nxt;
  logic [SAMPLE_BITS-1:0] upd_peak, upd_trough;
  logic                   upd_seen;
  logic                   acc;

  assign in_ready = !win_valid_r || win_ready;
  assign acc      = in_valid && in_ready;

  // running extremes including the current sample
  always_comb begin
    upd_peak   = peak_r;
    upd_trough = trough_r;
    upd_seen   = seen_r;
    if (in_data.sample_valid) begin
      if (in_data.sample_mv > peak_r) upd_peak = in_data.sample_mv;
      if (in_data.sample_mv < trough_r) upd_trough = in_data.sample_mv;
      upd_seen = 1'b1;
    end
  end

  always_comb begin
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    seen_nxt      = seen_r;
    win_nxt       = win_r;
    win_valid_nxt = win_valid_r && !win_ready;
    if (acc) begin
      if (in_data.window_end) begin
        win_nxt.peak   = upd_peak;
        win_nxt.trough = upd_trough;
        win_nxt.seen   = upd_seen;
        win_valid_nxt  = 1'b1;
        peak_nxt       = '0;
        trough_nxt     = '1;
        seen_nxt       = 1'b0;
      end else begin
        peak_nxt   = upd_peak;
        trough_nxt = upd_trough;
        seen_nxt   = upd_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      trough_r    <= '1;
      seen_r      <= 1'b0;
      win_valid_r <= 1'b0;
    end else begin
      peak_r      <= peak_nxt;
      trough_r    <= trough_nxt;
      seen_r      <= seen_nxt;
      win_valid_r <= win_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;

endmodule
`default_nettype wire

/* hdl/psd_scale.sv */
`default_nettype none
module psd_scale (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire psd_pkg::cfg_t cfg,
  input  wire logic          win_valid,
  output logic               win_ready,
  input  wire psd_pkg::win_t win,
  output logic               prod_valid,
  input  wire logic          prod_ready,
  output psd_pkg::prod_t     prod
);
  import psd_pkg::*;

  logic                     prod_valid_r, prod_valid_nxt;
  prod_t                    prod_r, prod_nxt;
  logic signed [DIFF_W-1:0] high_diff, low_diff;
  logic signed [PROD_W-1:0] gain_ext;
  logic                     adv;

  assign win_ready = !prod_valid_r || prod_ready;
  assign adv       = win_valid && win_ready;

  // offset removal, both operands are below half the diff range
  assign high_diff = $signed(DIFF_W'(win.peak)) - $signed(DIFF_W'(cfg.zero_offset));
  assign low_diff  = $signed(DIFF_W'(win.trough)) - $signed(DIFF_W'(cfg.zero_offset));
  assign gain_ext  = $signed(PROD_W'(cfg.gain_q12));

  always_comb begin
    prod_nxt           = prod_r;
    prod_valid_nxt     = prod_valid_r && !prod_ready;
    if (adv) begin
      prod_nxt.high_prod = PROD_W'(high_diff) * gain_ext;
      prod_nxt.low_prod  = PROD_W'(low_diff) * gain_ext;
      prod_nxt.empty     = !win.seen;
      prod_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule
`default_nettype wire

/* hdl/psd_classify.sv */
`default_nettype none
module psd_classify (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire psd_pkg::cfg_t  cfg,
  input  wire logic           prod_valid,
  output logic                prod_ready,
  input  wire psd_pkg::prod_t prod,
  output logic                out_valid,
  input  wire logic           out_ready,
  output psd_pkg::out_item_t  out_data
);
  import psd_pkg::*;

  localparam int QW = PROD_W - FRAC_BITS;

  logic [2:0]             cand_r, cand_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [2:0]             comm_r, comm_nxt;
  logic signed [MV_W-1:0] last_high_r, last_high_nxt;
  logic signed [MV_W-1:0] last_low_r, last_low_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;
  logic signed [MV_W-1:0] high_mv, low_mv;
  logic [2:0]             det;
  logic                   changed;
  logic                   adv;

  // divide by 2^FRAC_BITS rounding toward zero, then clamp to MV_W bits
  function automatic logic signed [MV_W-1:0] to_mv(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic signed [QW-1:0]     q;
    logic                     ovf;
    biased = p + (p[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));
    q      = QW'(biased >>> FRAC_BITS);
    ovf    = (q[QW-1:MV_W-1] != {(QW-MV_W+1){q[QW-1]}});
    if (ovf) to_mv = q[QW-1] ? {1'b1, {(MV_W-1){1'b0}}} : {1'b0, {(MV_W-1){1'b1}}};
    else     to_mv = q[MV_W-1:0];
  endfunction

  assign prod_ready = !out_valid_r || out_ready;
  assign adv        = prod_valid && prod_ready;

  assign high_mv = to_mv(prod.high_prod);
  assign low_mv  = to_mv(prod.low_prod);

  always_comb begin
    if (high_mv >= cfg.thr_not_connected)    det = ST_STANDBY;
    else if (high_mv >= cfg.thr_connected)   det = ST_CONNECTED;
    else if (high_mv >= cfg.thr_ready)       det = ST_CHARGING;
    else if (high_mv >= cfg.thr_ventilation) det = ST_VENTILATION;
    else                                     det = ST_NO_POWER;
    // missing diode
    if (cfg.pwm_active && det != ST_STANDBY && low_mv > cfg.thr_neg_rail) det = ST_ERROR;
  end

  always_comb begin
    cand_nxt      = cand_r;
    cnt_nxt       = cnt_r;
    comm_nxt      = comm_r;
    last_high_nxt = last_high_r;
    last_low_nxt  = last_low_r;
    changed       = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (adv) begin
      if (!prod.empty) begin
        last_high_nxt = high_mv;
        last_low_nxt  = low_mv;
        if (det == cand_r) begin
          if (cnt_r < CNT_W'(STABLE_COUNT)) cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          cand_nxt = det;
          cnt_nxt  = '0;
        end
        if (cnt_nxt >= CNT_W'(STABLE_COUNT) && cand_nxt != comm_r) begin
          comm_nxt = cand_nxt;
          changed  = 1'b1;
        end
      end
      out_nxt.vehicle_state = comm_nxt;
      out_nxt.high_mv       = last_high_nxt;
      out_nxt.low_mv        = last_low_nxt;
      out_nxt.state_changed = changed;
      out_nxt.window_empty  = prod.empty;
      out_valid_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r      <= ST_ERROR;
      cnt_r       <= '0;
      comm_r      <= ST_STANDBY;
      last_high_r <= '0;
      last_low_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cand_r      <= cand_nxt;
      cnt_r       <= cnt_nxt;
      comm_r      <= comm_nxt;
      last_high_r <= last_high_nxt;
      last_low_r  <= last_low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* hdl/pilot_state_detector.sv */
// pilot state detector
// input channel (in_valid / in_ready): one ADC sample transaction per cycle while in_ready is high,
//   carrying sample_mv, sample_valid and window_end; a valid sample extends
//   the running peak and trough of the open window
// a transaction with window_end set closes the window after its own sample
//   and yields exactly one result transaction; other transactions yield none
// result channel (out_valid / out_ready): committed vehicle state, converted
//   peak and trough in pilot millivolts, state_changed and window_empty
// after its closing transaction is taken, a result passes through the window
//   register, the multiplier register and the classify/output register
// throughput: one input transaction per cycle while out_ready keeps results
//   draining; each window close costs one pass through the two-multiplier scale
//   stage and the debounce register, each taking a new window as it passes one on
// stall: the three stages form an elastic pipeline, so up to three results
//   may queue while out_ready is low; in_ready drops only once all three
//   are full and rises again combinationally in the same cycle as out_ready
// reset (rst_n low, synchronous): open window cleared, debounce candidate
//   set to error with count zero, committed state standby, last peak/trough
//   zero, registers at their defaults, no result pending
// configuration: cfg_we writes cfg_wdata into register cfg_index at once;
//   write only while no transaction is in flight
`default_nettype none
`include "pilot_state_detector_macros.svh"
module pilot_state_detector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire psd_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output psd_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import psd_pkg::*;

  cfg_t  cfg;
  win_t  win;
  prod_t prod;
  logic  win_valid, win_ready;
  logic  prod_valid, prod_ready;

  // register bank
  psd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // peak/trough tracking, hands over closed windows
  psd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win)
  );

  // offset and gain multiply
  psd_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .win        (win),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  // shift, saturate, threshold, debounce, result register
  psd_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // input stalls only when every stage holds a window
  `PSD_ASSERT_NOW(a_stall_full, clk, rst_n, !in_ready, win_valid && prod_valid && out_valid)
  // an empty window never commits a change
  `PSD_ASSERT_NOW(a_empty_nochange, clk, rst_n, out_valid && out_data.window_empty,
    !out_data.state_changed)
  // a closing transaction always reaches the window register
  `PSD_ASSERT_NEXT(a_close_taken, clk, rst_n, in_valid && in_ready && in_data.window_end,
    win_valid)

endmodule
`default_nettype wire

/* test/tb_pilot_state_detector.sv */
`timescale 1ns / 1ps

module tb_pilot_state_detector;
  import psd_pkg::*;

  // tracks the open window, the debounce stage and the reports still owed by the block
  class pilot_state_tracker;
    // shadow of the configuration registers
    logic                   pwm_on;
    logic [OFFSET_W-1:0]    offset_mv;
    logic [GAIN_W-1:0]      gain;
    logic signed [MV_W-1:0] thr_nc, thr_conn, thr_rdy, thr_vent, thr_rail;
    // running window
    logic [SAMPLE_BITS-1:0] peak, trough;
    logic                   seen;
    // debounce
    logic [2:0]             cand_state, held_state;
    int                     hits;
    logic signed [MV_W-1:0] last_hi, last_lo;
    out_item_t              pending_reports[$];
    int                     mismatches;

    function new();
      mismatches = 0;
      reset_state();
    endfunction

    function void open_window();
      peak = '0;
      trough = '1;
      seen = 1'b0;
    endfunction

    function void reset_state();
      pwm_on = 1'b0;
      offset_mv = '0;
      gain = 16'd4096;
      thr_nc = 16'sd11000;
      thr_conn = 16'sd8000;
      thr_rdy = 16'sd5000;
      thr_vent = 16'sd2000;
      thr_rail = -16'sd11000;
      open_window();
      cand_state = ST_ERROR;
      hits = 0;
      held_state = ST_STANDBY;
      last_hi = '0;
      last_lo = '0;
      pending_reports.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PWM_ACTIVE:        pwm_on = val[0];
        REG_ZERO_OFFSET:       offset_mv = val[OFFSET_W-1:0];
        REG_GAIN_Q12:          gain = val[GAIN_W-1:0];
        REG_THR_NOT_CONNECTED: thr_nc = $signed(val[MV_W-1:0]);
        REG_THR_CONNECTED:     thr_conn = $signed(val[MV_W-1:0]);
        REG_THR_READY:         thr_rdy = $signed(val[MV_W-1:0]);
        REG_THR_VENTILATION:   thr_vent = $signed(val[MV_W-1:0]);
        REG_THR_NEG_RAIL:      thr_rail = $signed(val[MV_W-1:0]);
        default: ;
      endcase
    endfunction

    // (x - offset) * gain / 4096, truncated toward zero, saturated to 16 bits
    function logic signed [MV_W-1:0] scale_to_pilot(logic [SAMPLE_BITS-1:0] x);
      longint prod, q;
      prod = (longint'(x) - longint'(offset_mv)) * longint'(gain);
      if (prod < 0) q = -((-prod) >> FRAC_BITS);
      else q = prod >> FRAC_BITS;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[MV_W-1:0];
    endfunction

    function logic [2:0] classify(logic signed [MV_W-1:0] hi, logic signed [MV_W-1:0] lo);
      logic [2:0] s;
      if (hi >= thr_nc) s = ST_STANDBY;
      else if (hi >= thr_conn) s = ST_CONNECTED;
      else if (hi >= thr_rdy) s = ST_CHARGING;
      else if (hi >= thr_vent) s = ST_VENTILATION;
      else s = ST_NO_POWER;
      // missing diode only matters off standby
      if (pwm_on && s != ST_STANDBY && lo > thr_rail) s = ST_ERROR;
      return s;
    endfunction

    function void accept_sample(in_item_t it);
      out_item_t  rpt;
      logic [2:0] det;
      logic       changed;
      if (it.sample_valid) begin
        if (it.sample_mv > peak) peak = it.sample_mv;
        if (it.sample_mv < trough) trough = it.sample_mv;
        seen = 1'b1;
      end
      if (!it.window_end) return;
      changed = 1'b0;
      if (seen) begin
        last_hi = scale_to_pilot(peak);
        last_lo = scale_to_pilot(trough);
        det = classify(last_hi, last_lo);
        if (det == cand_state) begin
          if (hits < STABLE_COUNT) hits++;
        end else begin
          cand_state = det;
          hits = 0;
        end
        if (hits >= STABLE_COUNT && cand_state != held_state) begin
          held_state = cand_state;
          changed = 1'b1;
        end
      end
      rpt.vehicle_state = held_state;
      rpt.high_mv = last_hi;
      rpt.low_mv = last_lo;
      rpt.state_changed = changed;
      rpt.window_empty = !seen;
      open_window();
      pending_reports.push_back(rpt);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        $error("result transaction with no closed window: vehicle_state %0d", got.vehicle_state);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.vehicle_state !== want.vehicle_state) begin
        $error("vehicle_state: expected %0d, got %0d", want.vehicle_state, got.vehicle_state);
        mismatches++;
      end
      if (got.high_mv !== want.high_mv) begin
        $error("high_mv: expected %0d, got %0d", want.high_mv, got.high_mv);
        mismatches++;
      end
      if (got.low_mv !== want.low_mv) begin
        $error("low_mv: expected %0d, got %0d", want.low_mv, got.low_mv);
        mismatches++;
      end
      if (got.state_changed !== want.state_changed) begin
        $error("state_changed: expected %0d, got %0d", want.state_changed, got.state_changed);
        mismatches++;
      end
      if (got.window_empty !== want.window_empty) begin
        $error("window_empty: expected %0d, got %0d", want.window_empty, got.window_empty);
        mismatches++;
      end
    endfunction
  endclass

  // all block inputs start at known values
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pilot_state_tracker tracker;

  // idling knobs, percent per cycle
  int send_idle_pct = 0;
  int stall_pct = 0;
  // long receiver hold-off: main bumps hold_req, the receiver process counts it out
  int hold_len = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  // input transactions taken by the block
  int items_sent = 0;

  pilot_state_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: everything sampled at the edge, results checked before the new
  // input transaction is folded in
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_report(out_data);
      if (in_valid && in_ready) tracker.accept_sample(in_data);
      if (cfg_we) tracker.set_reg(cfg_index, cfg_wdata);
    end
  end

  // one input transaction; returns at the edge where it was taken, valid left high
  task automatic send_item(input logic [SAMPLE_BITS-1:0] smp, input logic vld,
                           input logic wend);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.sample_mv = smp;
    it.sample_valid = vld;
    it.window_end = wend;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // a window of samples around one level, closed on its last transaction;
  // dip drops one sample toward zero so the trough clears the negative rail
  task automatic send_window(input int len, input int level, input int spread, input bit dip);
    int smp;
    int dip_at;
    dip_at = int'($urandom_range(len - 1));
    for (int i = 0; i < len; i++) begin
      smp = level + int'($urandom_range(2 * spread)) - spread;
      if (dip && i == dip_at) smp = int'($urandom_range(300));
      if (smp < 0) smp = 0;
      if (smp > 4095) smp = 4095;
      send_item(smp[SAMPLE_BITS-1:0], $urandom_range(7) != 0, i == len - 1);
    end
  endtask

  // stop offering, wait for every owed result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register load, only once the block is idle; unused upper bits get noise
  task automatic load_config(input logic pwm, input int offs, input int gn, input int nc,
                             input int conn, input int rdy, input int vent, input int rail);
    wait_idle();
    write_reg(REG_PWM_ACTIVE, {15'($urandom), pwm});
    write_reg(REG_ZERO_OFFSET, {4'($urandom), offs[OFFSET_W-1:0]});
    write_reg(REG_GAIN_Q12, gn[15:0]);
    write_reg(REG_THR_NOT_CONNECTED, nc[15:0]);
    write_reg(REG_THR_CONNECTED, conn[15:0]);
    write_reg(REG_THR_READY, rdy[15:0]);
    write_reg(REG_THR_VENTILATION, vent[15:0]);
    write_reg(REG_THR_NEG_RAIL, rail[15:0]);
    cfg_we <= 1'b0;
  endtask

  // random pwm, offset, gain and negative rail, descending thresholds
  task automatic load_random_config();
    int nc, conn, rdy, vent;
    nc = int'($urandom_range(30000)) - 15000;
    conn = nc - int'($urandom_range(5000));
    rdy = conn - int'($urandom_range(5000));
    vent = rdy - int'($urandom_range(5000));
    load_config(1'($urandom_range(1)), int'($urandom_range(4095)),
                int'($urandom_range(2048, 40000)), nc, conn, rdy, vent,
                -int'($urandom_range(16000)));
  endtask

  // mostly debounce-friendly bursts of similar windows, some empty windows, some noise
  task automatic run_random(input int n, input int idle_in, input int stall_in,
                            input int dip_pct);
    int goal, pick, level, reps;
    send_idle_pct = idle_in;
    stall_pct = stall_in;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = int'($urandom_range(99));
      if (pick < 72) begin
        if (pick < 8) level = (pick % 2 == 1) ? 4095 : 0;
        else level = int'($urandom_range(4095));
        reps = int'($urandom_range(1, 5));
        repeat (reps) begin
          send_window(int'($urandom_range(1, 6)), level, int'($urandom_range(120)),
                      $urandom_range(99) < dip_pct);
        end
      end else if (pick < 82) begin
        // empty window, junk on the sample field
        repeat ($urandom_range(3)) send_item(SAMPLE_BITS'($urandom), 1'b0, 1'b0);
        send_item(SAMPLE_BITS'($urandom), 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(SAMPLE_BITS'($urandom), 1'($urandom_range(1)), $urandom_range(5) == 0);
        end
      end
    end
  endtask

  // receiver holds off for a long stretch while closing transactions keep coming,
  // so the result pipeline fills and in_ready drops; then the sender waits it out
  task automatic squeeze_output();
    send_idle_pct = 0;
    hold_len = 40;
    hold_req++;
    repeat (16) send_item(SAMPLE_BITS'($urandom), 1'b1, 1'b1);
    wait_idle();
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: pilot mV equals ADC mV
    send_item(12'hABC, 1'b0, 1'b1);   // empty window straight out of reset
    send_item(12'd4095, 1'b1, 1'b0);  // full-scale peak
    send_item(12'd0, 1'b1, 1'b1);     // zero trough, sample in the closing step
    repeat (3) send_item(12'd3000, 1'b1, 1'b1);  // third repeat commits
    send_item(12'hFFF, 1'b0, 1'b0);   // ignored sample must not raise the peak
    send_item(12'd500, 1'b1, 1'b1);
    send_item(12'd0, 1'b0, 1'b1);     // empty window repeats the last peak/trough

    // realistic scaling: walk through every threshold band
    load_config(1'b0, 2048, 24576, 11000, 8000, 5000, 2000, -11000);
    send_item(12'd4000, 1'b1, 1'b1);
    send_item(12'd3500, 1'b1, 1'b1);
    send_item(12'd3000, 1'b1, 1'b1);
    send_item(12'd2500, 1'b1, 1'b1);
    send_item(12'd1000, 1'b1, 1'b1);

    // pwm on: diode check
    load_config(1'b1, 2048, 24576, 11000, 8000, 5000, 2000, -11000);
    send_item(12'd3000, 1'b1, 1'b1);  // trough high, forced error
    send_item(12'd3000, 1'b1, 1'b0);
    send_item(12'd0, 1'b1, 1'b1);     // trough below the rail, no error
    send_item(12'd4000, 1'b1, 1'b1);  // standby skips the diode check
    repeat (4) send_item(12'd3100, 1'b1, 1'b1);  // error gets committed

    // random phases
    run_random(90, 0, 0, 40);
    load_config(1'b0, 2048, 24576, 11000, 8000, 5000, 2000, -11000);
    run_random(90, 50, 0, 20);
    squeeze_output();
    load_random_config();
    run_random(90, 0, 50, 30);

    // extremes: positive saturation, top thresholds
    load_config(1'b1, 0, 65535, 32767, 32767, -32768, -32768, -32768);
    run_random(40, 28, 28, 30);
    // negative saturation, rail at its top
    load_config(1'b1, 4095, 65535, 0, -100, -20000, -32768, 32767);
    run_random(40, 28, 28, 30);
    // zero gain pins everything at 0 mV
    load_config(1'b0, 0, 0, 1, 0, 0, 0, 0);
    run_random(30, 28, 28, 30);
    load_random_config();
    run_random(90, 28, 28, 30);

    // drain and let the pipeline settle
    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
